// ----- sv/lapedge_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lapedge_pkg
// Shared types and constants of the RGB 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
package lapedge_pkg;

	localparam int PIX_W   = 24;   // {red, green, blue}
	localparam int CHAN_W  = 8;
	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int NSLOT   = 3;

	// result slots of one pixel, in delivery order
	localparam int SLOT_FIRST  = 0;  // (x,0) on row 1, else (x-1,y-1)
	localparam int SLOT_RIGHT  = 1;  // right border pixel (W-1,y-1)
	localparam int SLOT_BOTTOM = 2;  // bottom border pixel (x,y)

	typedef struct packed {
		logic [NSLOT-1:0]   slots;   // which results this pixel releases
		logic               lap;     // first slot carries the filter value
		logic [COORD_W-1:0] col0;
		logic [COORD_W-1:0] row0;    // row of first and right border results
		logic [COORD_W-1:0] col1;
		logic [COORD_W-1:0] col2;
		logic [COORD_W-1:0] row2;
		logic               done2;   // bottom result closes the frame
	} item_ctl_t;

endpackage
`default_nettype wire

// ----- sv/lapedge_line_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lapedge_line_buf
// Two line stores: one read per pixel, middle written in the same cycle,
// upper written in the cycle after with the old middle entry.
// ----------------------------------------------------------------------------
module lapedge_line_buf
	import lapedge_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [PIX_W-1:0]         wr_pix,
	output logic      [PIX_W-1:0]         up_rd,
	output logic      [PIX_W-1:0]         mid_rd
);

	logic [PIX_W-1:0]         upper_mem  [DEPTH];
	logic [PIX_W-1:0]         middle_mem [DEPTH];
	logic [$clog2(DEPTH)-1:0] wr_addr_s1;
	logic                     shift_s1;

	// read-first: the registered read sees the entry before this write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_rd              <= upper_mem[addr];
			mid_rd             <= middle_mem[addr];
			middle_mem[addr]   <= wr_pix;
			wr_addr_s1         <= addr;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_s1) begin
			upper_mem[wr_addr_s1] <= mid_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
		end else begin
			shift_s1 <= rd_en;
		end
	end

	// the delayed upper write never collides with the next read
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		shift_s1 && rd_en |-> addr != wr_addr_s1)
		else $error("line store read hits pending upper write");

endmodule
`default_nettype wire

// ----- sv/lapedge_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lapedge_lane
// One colour channel: 8*centre minus neighbour sum, clamped to 0..255.
// Neighbour sum is registered, subtract and clamp follow the register.
// ----------------------------------------------------------------------------
module lapedge_lane
	import lapedge_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [8:0][CHAN_W-1:0] taps,
	output logic      [CHAN_W-1:0]     lane_val
);

	logic [8:0]  p0, p1, p2, p3;
	logic [9:0]  q0, q1;
	logic [10:0] nsum;
	logic [10:0] nsum_s3;
	logic [7:0]  ctr_s3;
	logic signed [11:0] diff;

	always_comb begin
		p0   = {1'b0, taps[0]} + {1'b0, taps[1]};
		p1   = {1'b0, taps[2]} + {1'b0, taps[3]};
		p2   = {1'b0, taps[5]} + {1'b0, taps[6]};
		p3   = {1'b0, taps[7]} + {1'b0, taps[8]};
		q0   = {1'b0, p0} + {1'b0, p1};
		q1   = {1'b0, p2} + {1'b0, p3};
		nsum = {1'b0, q0} + {1'b0, q1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nsum_s3 <= nsum;
			ctr_s3  <= taps[4];
		end
	end

	always_comb begin
		diff = $signed({1'b0, ctr_s3, 3'b000}) - $signed({1'b0, nsum_s3});
		if (diff < 12'sd0) begin
			lane_val = '0;
		end else if (diff > 12'sd255) begin
			lane_val = '1;
		end else begin
			lane_val = diff[CHAN_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- sv/lapedge_out.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lapedge_out
// Merge stage: takes the three lane values and the pixel's result slots,
// holds them in the output register and sends one result per beat.
// ----------------------------------------------------------------------------
module lapedge_out
	import lapedge_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire item_ctl_t        in_ctl,
	input  wire logic [PIX_W-1:0] in_pix,      // {red, green, blue}
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// edge_red[7:0], edge_green[15:8], edge_blue[23:16],
	// out_column[33:24], out_row[43:34], zero[47:44]
	output logic      [47:0]      m_axis_tdata,
	output logic                  m_axis_tlast // frame_done
);

	logic [NSLOT-1:0]   slots_q;
	item_ctl_t          ctl_q;
	logic [PIX_W-1:0]   lap_q;
	logic [NSLOT-1:0]   lowest;
	logic [NSLOT-1:0]   rem;
	logic               fire;
	logic [PIX_W-1:0]   cur_pix;
	logic [COORD_W-1:0] cur_col;
	logic [COORD_W-1:0] cur_row;
	logic               cur_last;

	assign lowest        = slots_q & (~slots_q + NSLOT'(1));
	assign rem           = slots_q & ~lowest;
	assign m_axis_tvalid = slots_q != '0;
	assign fire          = m_axis_tvalid && m_axis_tready;
	assign in_ready      = (slots_q == '0) || (fire && rem == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (in_valid && in_ready) begin
			slots_q <= in_ctl.slots;
		end else if (fire) begin
			slots_q <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_q <= in_ctl;
			lap_q <= in_ctl.lap ? in_pix : '0;
		end
	end

	always_comb begin
		cur_pix  = '0;
		cur_last = 1'b0;
		if (slots_q[SLOT_FIRST]) begin
			cur_pix = lap_q;
			cur_col = ctl_q.col0;
			cur_row = ctl_q.row0;
		end else if (slots_q[SLOT_RIGHT]) begin
			cur_col = ctl_q.col1;
			cur_row = ctl_q.row0;
		end else begin
			cur_col  = ctl_q.col2;
			cur_row  = ctl_q.row2;
			cur_last = ctl_q.done2;
		end
	end

	assign m_axis_tdata = {4'b0000, cur_row, cur_col,
		cur_pix[7:0], cur_pix[15:8], cur_pix[23:16]};
	assign m_axis_tlast = cur_last;

endmodule
`default_nettype wire

// ----- sv/rgb_laplacian_edge_3x3.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_laplacian_edge_3x3
// 3x3 Laplacian edge filter on a raster-order RGB pixel stream.
//
// Pixels enter on s_axis (one beat per pixel, red in the low byte). Results
// leave on m_axis, each beat carrying its clamped RGB value, column and row;
// tlast marks the last pixel of the frame. Border pixels come out as zero.
// The output trails the input by one row and one column: a pixel of row y
// releases results of row y-1, the last column also the right border pixel,
// the last row also its own pixel.
// An accepted pixel's first result is registered in turn by the line store
// read, the window, the lane sums and the output register.
// Throughput: one pixel per cycle; the output port sends one result per
// beat, so a pixel that releases two or three results holds s_axis for as
// many beats. The three colour lanes work in parallel.
// A stalled receiver fills the pipeline, then s_axis_tready drops.
// Reset clears counts, window and pipeline; width and height return to
// 640 x 480. Line stores need no clearing. Change frame_width/frame_height
// (APB, byte addresses 0 and 4) only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_laplacian_edge_3x3
	import lapedge_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// edge_red[7:0], edge_green[15:8], edge_blue[23:16],
	// out_column[33:24], out_row[43:34], zero[47:44]
	output logic      [47:0] m_axis_tdata,
	output logic             m_axis_tlast  // frame_done
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// ---------------- configuration ----------------
	logic [DIM_W-1:0] width_q, height_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_WIDTH:  prdata = 32'(width_q);
				REG_HEIGHT: prdata = 32'(height_q);
				default:    prdata = '0;
			endcase
		end
	end

	// effective size minus one, saturated to 3..MAX
	logic [CW-1:0] w_m1;
	logic [RW-1:0] h_m1;

	always_comb begin
		if (width_q < DIM_W'(3)) begin
			w_m1 = CW'(2);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_m1 = CW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = CW'(width_q - DIM_W'(1));
		end
		if (height_q < DIM_W'(3)) begin
			h_m1 = RW'(2);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_m1 = RW'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = RW'(height_q - DIM_W'(1));
		end
	end

	// ---------------- pipeline control ----------------
	logic v1_q, v2_q, v3_q;
	logic rdy1, rdy2, rdy3, out_ready;
	logic accept, adv12, adv23;

	assign rdy3          = !v3_q || out_ready;
	assign rdy2          = !v2_q || rdy3;
	assign rdy1          = !v1_q || rdy2;
	assign s_axis_tready = rdy1;
	assign accept        = s_axis_tvalid && rdy1;
	assign adv12         = v1_q && rdy2;
	assign adv23         = v2_q && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (accept)     v1_q <= 1'b1;
			else if (adv12) v1_q <= 1'b0;
			if (adv12)      v2_q <= 1'b1;
			else if (adv23) v2_q <= 1'b0;
			if (adv23)      v3_q <= 1'b1;
			else if (v3_q && out_ready) v3_q <= 1'b0;
		end
	end

	// ---------------- position and result slots ----------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col, last_row, row_is1, row_ge2;
	item_ctl_t     ctl_in;

	assign last_col = col_q >= w_m1;
	assign last_row = row_q >= h_m1;
	assign row_is1  = row_q == RW'(1);
	assign row_ge2  = row_q >= RW'(2);

	always_comb begin
		ctl_in = '0;
		ctl_in.slots[SLOT_FIRST]  = row_is1 || (row_ge2 && col_q != '0);
		ctl_in.slots[SLOT_RIGHT]  = row_ge2 && col_q != '0 && last_col;
		ctl_in.slots[SLOT_BOTTOM] = last_row;
		ctl_in.lap   = row_ge2 && col_q >= CW'(2) && col_q <= w_m1 && row_q <= h_m1;
		ctl_in.col0  = row_is1 ? COORD_W'(col_q) : COORD_W'(col_q - CW'(1));
		ctl_in.row0  = row_is1 ? '0 : COORD_W'(row_q - RW'(1));
		ctl_in.col1  = COORD_W'(w_m1);
		ctl_in.col2  = COORD_W'(col_q);
		ctl_in.row2  = COORD_W'(row_q);
		ctl_in.done2 = last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- stage 1: line stores ----------------
	logic [PIX_W-1:0] pix_in, pix_s1, up_rd, mid_rd;
	item_ctl_t        ctl_s1, ctl_s2, ctl_s3;

	assign pix_in = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

	lapedge_line_buf #(.DEPTH(MAX_WIDTH)) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.addr   (col_q),
		.wr_pix (pix_in),
		.up_rd  (up_rd),
		.mid_rd (mid_rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_in;
			ctl_s1 <= ctl_in;
		end
		if (adv12) ctl_s2 <= ctl_s1;
		if (adv23) ctl_s3 <= ctl_s2;
	end

	// ---------------- stage 2: 3x3 window ----------------
	// index r*3+c, row 0 upper, column 2 newest
	logic [PIX_W-1:0] win_s2 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_s2[i] <= '0;
		end else if (adv12) begin
			for (int r = 0; r < 3; r++) begin
				win_s2[r*3]   <= win_s2[r*3+1];
				win_s2[r*3+1] <= win_s2[r*3+2];
			end
			win_s2[2] <= up_rd;
			win_s2[5] <= mid_rd;
			win_s2[8] <= pix_s1;
		end
	end

	// ---------------- stage 3: colour lanes ----------------
	logic [2:0][CHAN_W-1:0] lane_val;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [8:0][CHAN_W-1:0] taps;

		always_comb begin
			for (int i = 0; i < 9; i++) begin
				taps[i] = win_s2[i][PIX_W-1-CHAN_W*c -: CHAN_W];
			end
		end

		lapedge_lane u_lane (
			.clk      (clk),
			.en       (adv23),
			.taps     (taps),
			.lane_val (lane_val[c])
		);
	end

	// ---------------- merge and output ----------------
	lapedge_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v3_q),
		.in_ready      (out_ready),
		.in_ctl        (ctl_s3),
		.in_pix        ({lane_val[0], lane_val[1], lane_val[2]}),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(MAX_WIDTH - 1) && row_q <= RW'(MAX_HEIGHT - 1))
		else $error("position count out of range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q && !v2_q && !v3_q |-> s_axis_tready)
		else $error("empty pipeline refuses input");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_col |=> col_q == $past(col_q) + CW'(1) && v1_q)
		else $error("column count did not advance");

endmodule
`default_nettype wire

// ----- test/rgb_laplacian_edge_3x3_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_laplacian_edge_3x3_tb
// Self-checking bench for the RGB 3x3 Laplacian edge filter.
//
// Whole frames of hand-picked and random pixels go in on s_axis. A bench-side
// copy of the line stores, window and raster counts predicts every result
// beat, and each beat on m_axis is checked field by field against the oldest
// prediction. Frame size is set over APB between frames (and mid-frame,
// shrinking only), including values that clamp. Both stream sides idle at
// random; one frame runs against a long receiver stall.
// ----------------------------------------------------------------------------
module rgb_laplacian_edge_3x3_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lapedge_pkg::*;

	localparam int LINE_MAX      = 1024;
	localparam int ROWS_MAX      = 1024;
	localparam int GAP_MAX       = 17;
	localparam int DRAIN_CYCLES  = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PIXELS = 25;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;     // low byte on the bus
	} rgb_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		rgb_t               value;
	} edge_beat_t;

	typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_SPIKES} pix_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // red[7:0], green[15:8], blue[23:16], col[33:24], row[43:34]
	logic        m_axis_tlast;

	// bench copy of the filter state
	rgb_t             upper_line [LINE_MAX];
	rgb_t             middle_line [LINE_MAX];
	rgb_t             win [3][3] = '{default: '0};
	int unsigned      col_cnt = 0;
	int unsigned      row_cnt = 0;
	logic [DIM_W-1:0] width_reg = 11'd640;
	logic [DIM_W-1:0] height_reg = 11'd480;

	edge_beat_t edge_results_due [$];

	int pixels_sent = 0;
	int results_checked = 0;
	int frames_sent = 0;
	int input_stall_cycles = 0;
	int mismatches = 0;

	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int          rx_hold = 0;
	pix_style_t  pix_style = STYLE_NOISE;
	logic [7:0]  smooth_floor = 8'd0;

	rgb_laplacian_edge_3x3 #(
		.MAX_WIDTH  (LINE_MAX),
		.MAX_HEIGHT (ROWS_MAX)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic int unsigned clamp_size(logic [DIM_W-1:0] v, int unsigned lim);
		if (v < 3)
			return 3;
		if (v > lim)
			return lim;
		return 32'(v);
	endfunction

	// 8*centre - ring == 9*centre - sum of all nine
	function automatic logic [CHAN_W-1:0] lap_lane(int lane);
		int centre;
		int total;
		int v;
		centre = int'(win[1][1][lane*CHAN_W +: CHAN_W]);
		total = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				total += int'(win[i][j][lane*CHAN_W +: CHAN_W]);
		v = 9 * centre - total;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CHAN_W-1:0];
	endfunction

	function automatic void queue_edge(rgb_t v, int unsigned c, int unsigned r, bit d);
		edge_beat_t b;
		b.value = v;
		b.col   = c[COORD_W-1:0];
		b.row   = r[COORD_W-1:0];
		b.done  = d;
		edge_results_due.push_back(b);
	endfunction

	function automatic void predict_edges(rgb_t px);
		int unsigned w, h, x, y, idx;
		bit          last_col, last_row, interior;
		rgb_t        up, mid, lap;
		w = clamp_size(width_reg, LINE_MAX);
		h = clamp_size(height_reg, ROWS_MAX);
		x = col_cnt;
		y = row_cnt;
		idx = (x < LINE_MAX) ? x : LINE_MAX - 1;
		up = upper_line[idx];
		mid = middle_line[idx];
		// counts past a shrunk edge still end the row / frame
		last_col = x >= w - 1;
		last_row = y >= h - 1;

		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = px;
		upper_line[idx] = mid;
		middle_line[idx] = px;

		if (y == 1) begin
			queue_edge('0, x, 0, 1'b0);
		end else if (y >= 2 && x >= 1) begin
			interior = x >= 2 && x <= w - 1 && y <= h - 1;
			lap = '0;
			if (interior) begin
				lap.red   = lap_lane(0);
				lap.green = lap_lane(1);
				lap.blue  = lap_lane(2);
			end
			queue_edge(lap, x - 1, y - 1, 1'b0);
			if (last_col)
				queue_edge('0, w - 1, y - 1, 1'b0);
		end
		if (last_row)
			queue_edge('0, x, y, last_col);

		if (last_col) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : y + 1;
		end else begin
			col_cnt = x + 1;
		end
	endfunction

	function automatic rgb_t draw_pixel();
		rgb_t px;
		case (pix_style)
			STYLE_SMOOTH: begin
				px.red   = smooth_floor + 8'($urandom_range(0, 15));
				px.green = smooth_floor + 8'($urandom_range(0, 15));
				px.blue  = smooth_floor + 8'($urandom_range(0, 15));
			end
			STYLE_SPIKES: begin
				px.red   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
				px.green = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
				px.blue  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
			end
			default: begin
				px = PIX_W'($urandom());
			end
		endcase
		return px;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// one pixel beat on s_axis; the model steps when the beat is taken
	task automatic send_pixel(input rgb_t px);
		int gap;
		gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		predict_edges(px);
		pixels_sent++;
	endtask

	task automatic send_to_frame_end();
		do
			send_pixel(draw_pixel());
		while (col_cnt != 0 || row_cnt != 0);
		frames_sent++;
	endtask

	// row 0 pixels release nothing, so allow for the pipeline after the queue drains
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (edge_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [2:0] addr,
	                          input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [2:0] addr, input logic [DIM_W-1:0] want);
		logic [31:0] rd;
		apb_access(1'b0, addr, '0, rd);
		check_field(addr == REG_FRAME_WIDTH ? "frame_width read" : "frame_height read",
		            32'(want), rd);
	endtask

	task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		logic [31:0] rd;
		wait_idle();
		apb_access(1'b1, REG_FRAME_WIDTH, 32'(w), rd);
		width_reg = w;
		apb_access(1'b1, REG_FRAME_HEIGHT, 32'(h), rd);
		height_reg = h;
		check_register(REG_FRAME_WIDTH, w);
		check_register(REG_FRAME_HEIGHT, h);
	endtask

	task automatic test_register_reset();
		check_register(REG_FRAME_WIDTH, 11'd640);
		check_register(REG_FRAME_HEIGHT, 11'd480);
	endtask

	// 3x3 frames, one interior pixel: clamp high, clamp low and an in-range lane
	task automatic test_small_frames();
		rgb_t centre, ring;
		set_frame_size(11'd3, 11'd3);
		for (int f = 0; f < 2; f++) begin
			// fields run blue, green, red
			centre = f ? rgb_t'{8'h80, 8'hFF, 8'h00} : rgb_t'{8'd40, 8'h00, 8'hFF};
			ring   = f ? rgb_t'{8'h7F, 8'h00, 8'hFF} : rgb_t'{8'd35, 8'hFF, 8'h00};
			for (int i = 0; i < 9; i++)
				send_pixel(i == 4 ? centre : ring);
			frames_sent++;
		end
	endtask

	// sizes that clamp to the limits; oversized frame is cut short once row 0 is under way
	task automatic test_size_limits();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		pix_style = STYLE_NOISE;
		set_frame_size(11'd2, 11'd0);
		send_to_frame_end();
		set_frame_size(11'd2047, 11'd1025);
		repeat (6) send_pixel(draw_pixel());
		set_frame_size(11'd3, 11'd3);
		send_to_frame_end();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_resize_mid_frame();
		pix_style = STYLE_SMOOTH;
		smooth_floor = 8'($urandom_range(0, 240));
		set_frame_size(11'd8, 11'd6);
		repeat (27) send_pixel(draw_pixel());
		// column 3 of row 3 now lies past the right edge
		set_frame_size(11'd3, 11'd6);
		send_pixel(draw_pixel());
		// row 4 now lies past the bottom edge
		set_frame_size(11'd3, 11'd3);
		send_to_frame_end();
	endtask

	task automatic test_back_pressure();
		tx_idle = 1'b0;
		pix_style = STYLE_SPIKES;
		set_frame_size(11'd8, 11'd4);
		rx_hold = HOLD_CYCLES;
		send_to_frame_end();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_frames();
		int first;
		first = pixels_sent;
		while (pixels_sent - first < RANDOM_PIXELS) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			pix_style = pix_style_t'($urandom_range(0, 2));
			smooth_floor = 8'($urandom_range(0, 240));
			set_frame_size(DIM_W'($urandom_range(0, 6)), DIM_W'($urandom_range(0, 5)));
			send_to_frame_end();
		end
	endtask

	// result beats against the oldest prediction
	always @(posedge clk) begin
		edge_beat_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (edge_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat expected none, got col %0d row %0d", $time,
				         m_axis_tdata[33:24], m_axis_tdata[43:34]);
			end else begin
				want = edge_results_due.pop_front();
				check_field("edge_red", 32'(want.value.red), 32'(m_axis_tdata[7:0]));
				check_field("edge_green", 32'(want.value.green), 32'(m_axis_tdata[15:8]));
				check_field("edge_blue", 32'(want.value.blue), 32'(m_axis_tdata[23:16]));
				check_field("out_column", 32'(want.col), 32'(m_axis_tdata[33:24]));
				check_field("out_row", 32'(want.row), 32'(m_axis_tdata[43:34]));
				check_field("frame_done", 32'(want.done), 32'(m_axis_tlast));
				results_checked++;
			end
		end
	end

	// receiver: random stall before each beat, or one long hold when asked
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (m_axis_tvalid !== 1'b1);
		end
	end

	initial begin
		#5ms;
		$display("rgb_laplacian_edge_3x3_tb failed");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reset();
		test_small_frames();
		test_size_limits();
		test_resize_mid_frame();
		test_back_pressure();
		test_random_frames();
		wait_idle();

		$display("Ran %0d frames, %0d pixels, %0d result beats checked (clamped sizes,",
		         frames_sent, pixels_sent, results_checked);
		$display("mid-frame shrink, %0d input stall cycles), %0d mismatches.",
		         input_stall_cycles, mismatches);
		if (mismatches == 0)
			$display("rgb_laplacian_edge_3x3_tb passed");
		else
			$display("rgb_laplacian_edge_3x3_tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lapedge_pkg.sv
sv/lapedge_line_buf.sv
sv/lapedge_lane.sv
sv/lapedge_out.sv
sv/rgb_laplacian_edge_3x3.sv
test/rgb_laplacian_edge_3x3_tb.sv
